// File: rtl/rmsac_pkg.sv
// Constants and codes for the RMS meter with two-phase auto calibration.
// No dependencies; imported by block_rms_meter_with_autocal and the testbench.
package rmsac_pkg;

   localparam int ADC_BITS   = 10;
   localparam int FRAC_BITS  = 4;
   localparam int OFS_W      = 16;
   localparam int RAW_W      = ADC_BITS + 1;
   localparam int VAL_W      = ((RAW_W + FRAC_BITS > OFS_W) ? RAW_W + FRAC_BITS : OFS_W) + 1;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int SQ_SUM_W   = 42;
   localparam int RAW_SUM_W  = 23;
   localparam int RAW_DIV_W  = RAW_SUM_W + FRAC_BITS;
   localparam int CNT_W      = 12;
   localparam int N_W        = CNT_W + 1;
   localparam int ROOT_W     = SQ_SUM_W / 2;
   localparam int SREM_W     = ROOT_W + 2;
   localparam int RMS_W      = 15;
   localparam int GHOST_W    = 10;
   localparam int PHASE_W    = 2;
   localparam int STEP_W     = 6;
   localparam int STATE_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_BLOCK = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_SCALE         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GHOST_THRESHOLD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_CAL_TICKS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_CAL_TICKS  = 3'd4;

   localparam logic [CNT_W-1:0]    RST_SAMPLES_PER_BLOCK = 12'd1000;
   localparam logic [ADC_BITS-1:0] RST_MID_SCALE         = ADC_BITS'(512);
   localparam logic [GHOST_W-1:0]  RST_GHOST_THRESHOLD   = 10'd40;
   localparam logic [CNT_W-1:0]    RST_FIRST_CAL_TICKS   = 12'd1500;
   localparam logic [CNT_W-1:0]    RST_SECOND_CAL_TICKS  = 12'd2500;

   localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PH_ZERO = 2'd1;
   localparam logic [PHASE_W-1:0] PH_RMS  = 2'd2;

   localparam logic [RMS_W-1:0]        RMS_MAX = 15'h7fff;
   localparam logic signed [OFS_W-1:0] OFS_MAX = 16'sh7fff;
   localparam logic signed [OFS_W-1:0] OFS_MIN = 16'sh8000;

endpackage

// File: rtl/block_rms_meter_with_autocal.sv
// RMS meter with two-phase auto calibration: bit-serial square, shared
// restoring divider and two-bit-per-step integer square root. Uses rmsac_pkg.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall adc_sample, calibrate_request
//   rsp      out        rsp_valid/rsp_stall rms_voltage, calibration_phase
//   csr      in         csr_valid/csr_ready index, wdata
//
// An item that ends no block runs the bit-serial square, then accumulate
// and finish. A block-end item adds 42 divider steps for the mean square,
// 21 root steps and 27 divider steps for the raw mean.
// req_stall is high while an item is in work; a finished result waits in the
// output register, and the next block-end item holds in its last cycle until
// that result is taken. Reset is synchronous and needs no clearing pass.
module block_rms_meter_with_autocal
   import rmsac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ADC_BITS-1:0]   req_adc_sample,
   input  logic                  req_calibrate_request,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [RMS_W-1:0]      rsp_rms_voltage,
   output logic [PHASE_W-1:0]    rsp_calibration_phase,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
   localparam logic [STATE_W-1:0] S_MUL  = 3'd1;
   localparam logic [STATE_W-1:0] S_ACC  = 3'd2;
   localparam logic [STATE_W-1:0] S_DIVS = 3'd3;
   localparam logic [STATE_W-1:0] S_SQRT = 3'd4;
   localparam logic [STATE_W-1:0] S_DIVR = 3'd5;
   localparam logic [STATE_W-1:0] S_FIN  = 3'd6;

   function automatic logic [N_W-1:0] eff_count(input logic [CNT_W-1:0] v);
      return (v == '0) ? (N_W'(1) << CNT_W) : {1'b0, v};
   endfunction

   function automatic logic signed [OFS_W-1:0] neg_sat(input logic signed [OFS_W-1:0] v);
      return (v == OFS_MIN) ? OFS_MAX : -v;
   endfunction

   // configuration
   logic [CNT_W-1:0]    spb_ff, spb_in;
   logic [ADC_BITS-1:0] mid_ff, mid_in;
   logic [GHOST_W-1:0]  ghost_ff, ghost_in;
   logic [CNT_W-1:0]    first_ff, first_in;
   logic [CNT_W-1:0]    second_ff, second_in;

   // architectural state
   logic [STATE_W-1:0]          state_ff, state_in;
   logic [SQ_SUM_W-1:0]         sq_sum_ff, sq_sum_in;
   logic signed [RAW_SUM_W-1:0] raw_sum_ff, raw_sum_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic signed [OFS_W-1:0]     zero_ofs_ff, zero_ofs_in;
   logic signed [OFS_W-1:0]     rms_ofs_ff, rms_ofs_in;
   logic signed [OFS_W-1:0]     lrm_ff, lrm_in;
   logic [RMS_W-1:0]            lsr_ff, lsr_in;
   logic [PHASE_W-1:0]          phase_ff, phase_in;
   logic [CNT_W-1:0]            ticks_ff, ticks_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [RMS_W-1:0]        rsp_rms_ff, rsp_rms_in;
   logic [PHASE_W-1:0]      rsp_phase_ff, rsp_phase_in;
   logic signed [RAW_W-1:0] raw_ff, raw_in;
   logic [VAL_W-1:0]        mcand_ff, mcand_in;
   logic [PROD_W:0]         prod_ff, prod_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [SQ_SUM_W-1:0]     q_ff, q_in;
   logic [N_W-1:0]          rem_ff, rem_in;
   logic [N_W-1:0]          n_ff, n_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [SREM_W-1:0]       srem_ff, srem_in;
   logic                    req_ff, req_in;
   logic                    end_ff, end_in;
   logic                    neg_ff, neg_in;

   // combinational helpers
   logic signed [RAW_W-1:0]     raw_c;
   logic signed [VAL_W-1:0]     val_c;
   logic [VAL_W:0]              hi_sum;
   logic [SQ_SUM_W-1:0]         sq_sum_new;
   logic signed [RAW_SUM_W-1:0] raw_sum_new;
   logic [N_W-1:0]              n_c;
   logic [N_W:0]                div_rs, div_diff;
   logic                        div_ge;
   logic [SREM_W+1:0]           sq_rr, sq_trial, sq_diff;
   logic                        sq_ge;
   logic [RAW_SUM_W-1:0]        raw_mag;
   logic [RAW_DIV_W-1:0]        qmag;
   logic [ROOT_W:0]             scaled;
   logic [RMS_W-1:0]            lsr_c;
   logic signed [OFS_W-1:0]     lrm_c;
   logic signed [RMS_W+2:0]     fin_val;
   logic [RMS_W-1:0]            result_c;
   logic [PHASE_W-1:0]          ph;
   logic [N_W-1:0]              t_c;
   logic                        out_free;

   assign req_stall             = (state_ff != S_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_rms_voltage       = rsp_rms_ff;
   assign rsp_calibration_phase = rsp_phase_ff;
   assign out_free              = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      raw_c = $signed({1'b0, req_adc_sample}) - $signed({1'b0, mid_ff});
      val_c = (VAL_W'(raw_c) <<< FRAC_BITS) + VAL_W'(zero_ofs_ff);

      hi_sum = prod_ff[0] ? (prod_ff[PROD_W:VAL_W] + {1'b0, mcand_ff})
                          : prod_ff[PROD_W:VAL_W];

      sq_sum_new  = sq_sum_ff + SQ_SUM_W'(prod_ff[PROD_W-1:0]);
      raw_sum_new = raw_sum_ff + RAW_SUM_W'(raw_ff);
      n_c         = {1'b0, count_ff} + N_W'(1);

      div_rs   = {rem_ff, q_ff[SQ_SUM_W-1]};
      div_diff = div_rs - {1'b0, n_ff};
      div_ge   = (div_rs >= {1'b0, n_ff});

      sq_rr    = {srem_ff, q_ff[SQ_SUM_W-1 -: 2]};
      sq_trial = (SREM_W+2)'({root_ff, 2'b01});
      sq_diff  = sq_rr - sq_trial;
      sq_ge    = (sq_rr >= sq_trial);

      raw_mag = raw_sum_ff[RAW_SUM_W-1] ? RAW_SUM_W'(-raw_sum_ff) : RAW_SUM_W'(raw_sum_ff);

      // block-end results
      scaled = {1'b0, root_ff} + {2'b00, root_ff[ROOT_W-1:1]};
      lsr_c  = (scaled > (ROOT_W+1)'(RMS_MAX)) ? RMS_MAX : scaled[RMS_W-1:0];
      qmag   = q_ff[RAW_DIV_W-1:0];
      if (neg_ff) begin
         lrm_c = (qmag > RAW_DIV_W'(32768)) ? OFS_MIN : OFS_W'(-qmag);
      end else begin
         lrm_c = (qmag > RAW_DIV_W'(32767)) ? OFS_MAX : OFS_W'(qmag);
      end
      fin_val = $signed({3'b000, lsr_c}) + (RMS_W+3)'(rms_ofs_ff);
      if (fin_val <= $signed({{(RMS_W+3-GHOST_W){1'b0}}, ghost_ff})) begin
         result_c = '0;
      end else if (fin_val > $signed({3'b000, RMS_MAX})) begin
         result_c = RMS_MAX;
      end else begin
         result_c = fin_val[RMS_W-1:0];
      end

      ph  = req_ff ? PH_ZERO : phase_ff;
      t_c = {1'b0, ticks_ff} + N_W'(1);
   end

   always_comb begin
      spb_in       = spb_ff;
      mid_in       = mid_ff;
      ghost_in     = ghost_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      state_in     = state_ff;
      sq_sum_in    = sq_sum_ff;
      raw_sum_in   = raw_sum_ff;
      count_in     = count_ff;
      zero_ofs_in  = zero_ofs_ff;
      rms_ofs_in   = rms_ofs_ff;
      lrm_in       = lrm_ff;
      lsr_in       = lsr_ff;
      phase_in     = phase_ff;
      ticks_in     = ticks_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rms_in   = rsp_rms_ff;
      rsp_phase_in = rsp_phase_ff;
      raw_in       = raw_ff;
      mcand_in     = mcand_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      n_in         = n_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      req_in       = req_ff;
      end_in       = end_ff;
      neg_in       = neg_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLES_PER_BLOCK: spb_in    = csr_wdata;
            CSR_MID_SCALE:         mid_in    = csr_wdata[ADC_BITS-1:0];
            CSR_GHOST_THRESHOLD:   ghost_in  = csr_wdata[GHOST_W-1:0];
            CSR_FIRST_CAL_TICKS:   first_in  = csr_wdata;
            CSR_SECOND_CAL_TICKS:  second_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff) inside
         S_IDLE: begin
            if (req_valid) begin
               raw_in   = raw_c;
               req_in   = req_calibrate_request;
               mcand_in = val_c[VAL_W-1] ? VAL_W'(-val_c) : VAL_W'(val_c);
               prod_in  = (PROD_W+1)'(val_c[VAL_W-1] ? VAL_W'(-val_c) : VAL_W'(val_c));
               step_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = {1'b0, hi_sum, prod_ff[VAL_W-1:1]};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(VAL_W-1)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            raw_sum_in = raw_sum_new;
            n_in       = n_c;
            if (n_c >= eff_count(spb_ff)) begin
               end_in    = 1'b1;
               q_in      = sq_sum_new;
               sq_sum_in = '0;
               count_in  = '0;
               rem_in    = '0;
               step_in   = '0;
               state_in  = S_DIVS;
            end else begin
               end_in    = 1'b0;
               sq_sum_in = sq_sum_new;
               count_in  = n_c[CNT_W-1:0];
               state_in  = S_FIN;
            end
         end
         S_DIVS, S_DIVR: begin
            rem_in  = div_ge ? div_diff[N_W-1:0] : div_rs[N_W-1:0];
            q_in    = {q_ff[SQ_SUM_W-2:0], div_ge};
            step_in = step_ff + STEP_W'(1);
            if (state_ff == S_DIVS && step_ff == STEP_W'(SQ_SUM_W-1)) begin
               srem_in  = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = S_SQRT;
            end else if (state_ff == S_DIVR && step_ff == STEP_W'(RAW_DIV_W-1)) begin
               state_in = S_FIN;
            end
         end
         S_SQRT: begin
            srem_in = sq_ge ? sq_diff[SREM_W-1:0] : sq_rr[SREM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], sq_ge};
            q_in    = q_ff << 2;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ROOT_W-1)) begin
               neg_in     = raw_sum_ff[RAW_SUM_W-1];
               q_in       = SQ_SUM_W'(RAW_DIV_W'(raw_mag) << FRAC_BITS) << (SQ_SUM_W - RAW_DIV_W);
               raw_sum_in = '0;
               rem_in     = '0;
               step_in    = '0;
               state_in   = S_DIVR;
            end
         end
         S_FIN: begin
            if (!end_ff || out_free) begin
               phase_in = ph;
               if (end_ff) begin
                  lsr_in = lsr_c;
                  lrm_in = lrm_c;
               end
               if (ph == PH_ZERO) begin
                  zero_ofs_in = '0;
                  if (t_c >= eff_count(first_ff)) begin
                     zero_ofs_in = neg_sat(end_ff ? lrm_c : lrm_ff);
                     phase_in    = PH_RMS;
                     ticks_in    = '0;
                  end else begin
                     ticks_in = t_c[CNT_W-1:0];
                  end
               end else if (ph == PH_RMS) begin
                  rms_ofs_in = '0;
                  if (t_c >= eff_count(second_ff)) begin
                     rms_ofs_in = neg_sat($signed({1'b0, end_ff ? lsr_c : lsr_ff}));
                     phase_in   = PH_IDLE;
                     ticks_in   = '0;
                  end else begin
                     ticks_in = t_c[CNT_W-1:0];
                  end
               end
               if (phase_in == PH_RMS) begin
                  rms_ofs_in = '0;
               end
               if (end_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_rms_in   = result_c;
                  rsp_phase_in = phase_in;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff       <= RST_SAMPLES_PER_BLOCK;
         mid_ff       <= RST_MID_SCALE;
         ghost_ff     <= RST_GHOST_THRESHOLD;
         first_ff     <= RST_FIRST_CAL_TICKS;
         second_ff    <= RST_SECOND_CAL_TICKS;
         state_ff     <= S_IDLE;
         sq_sum_ff    <= '0;
         raw_sum_ff   <= '0;
         count_ff     <= '0;
         zero_ofs_ff  <= '0;
         rms_ofs_ff   <= '0;
         lrm_ff       <= '0;
         lsr_ff       <= '0;
         phase_ff     <= PH_IDLE;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         spb_ff       <= spb_in;
         mid_ff       <= mid_in;
         ghost_ff     <= ghost_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         state_ff     <= state_in;
         sq_sum_ff    <= sq_sum_in;
         raw_sum_ff   <= raw_sum_in;
         count_ff     <= count_in;
         zero_ofs_ff  <= zero_ofs_in;
         rms_ofs_ff   <= rms_ofs_in;
         lrm_ff       <= lrm_in;
         lsr_ff       <= lsr_in;
         phase_ff     <= phase_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rms_ff   <= rsp_rms_in;
      rsp_phase_ff <= rsp_phase_in;
      raw_ff       <= raw_in;
      mcand_ff     <= mcand_in;
      prod_ff      <= prod_in;
      step_ff      <= step_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      n_ff         <= n_in;
      root_ff      <= root_in;
      srem_ff      <= srem_in;
      req_ff       <= req_in;
      end_ff       <= end_in;
      neg_ff       <= neg_in;
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for block_rms_meter_with_autocal: sample ticks, CSR writes,
// a sample-level predictor of block RMS and calibration phase, in-order result checks.
// Depends on rmsac_pkg and the block RTL.
module testbench;
   import rmsac_pkg::*;

   localparam int SETTLE_CYCLES = 150;
   localparam int CYCLE_LIMIT   = 500_000;
   localparam int CALM_FIRST    = 12_000;
   localparam int CALM_LAST     = 24_000;

   typedef struct packed {
      logic [ADC_BITS-1:0] adc;
      logic                cal;
   } tick_item_type;

   typedef struct packed {
      logic [RMS_W-1:0]   rms;
      logic [PHASE_W-1:0] phase;
   } reading_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ADC_BITS-1:0]   req_adc_sample = '0;
   logic                  req_calibrate_request = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [RMS_W-1:0]      rsp_rms_voltage;
   logic [PHASE_W-1:0]    rsp_calibration_phase;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tick_item_type pending_ticks[$];
   reading_type   expected_readings[$];
   int unsigned   cycle_count = 0;
   int unsigned   failures = 0;
   logic          calm;

   // register shadows
   logic [CNT_W-1:0]    blk_len      = RST_SAMPLES_PER_BLOCK;
   logic [ADC_BITS-1:0] mid          = RST_MID_SCALE;
   logic [GHOST_W-1:0]  ghost        = RST_GHOST_THRESHOLD;
   logic [CNT_W-1:0]    first_ticks  = RST_FIRST_CAL_TICKS;
   logic [CNT_W-1:0]    second_ticks = RST_SECOND_CAL_TICKS;

   // meter state
   logic [SQ_SUM_W-1:0] sq_acc      = '0;
   longint              raw_acc     = 0;
   logic [CNT_W-1:0]    blk_count   = '0;
   int                  zero_ofs    = 0;
   int                  rms_ofs     = 0;
   int                  raw_mean    = 0;
   int                  scaled_rms  = 0;
   logic [PHASE_W-1:0]  phase       = PH_IDLE;
   int                  phase_ticks = 0;

   block_rms_meter_with_autocal uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

   function automatic int count_limit(input logic [CNT_W-1:0] v);
      return (v == 0) ? 4096 : int'(v);
   endfunction

   function automatic int clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   function automatic longint int_root(input longint v);
      longint root;
      longint trial;
      root = 0;
      for (int b = 30; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   task automatic advance_meter(input logic [ADC_BITS-1:0] adc, input logic cal);
      longint      raw;
      longint      val;
      longint      n;
      longint      root;
      longint      scaled;
      longint      final_val;
      reading_type r;
      logic        done;
      done = 1'b0;
      r = '0;
      if (cal) phase = PH_ZERO;
      raw = longint'(adc) - longint'(mid);
      raw_acc += raw;
      val = raw * (longint'(1) << FRAC_BITS) + zero_ofs;
      sq_acc += SQ_SUM_W'(val * val);
      n = longint'(blk_count) + 1;
      if (n >= count_limit(blk_len)) begin
         root = int_root(longint'(sq_acc) / n);
         scaled = (root * 3) >>> 1;
         raw_mean = clamp16((raw_acc * (longint'(1) << FRAC_BITS)) / n);
         scaled_rms = (scaled > 32767) ? 32767 : int'(scaled);
         final_val = longint'(scaled_rms) + rms_ofs;
         if (final_val <= longint'(ghost)) r.rms = '0;
         else if (final_val > 32767) r.rms = RMS_MAX;
         else r.rms = RMS_W'(final_val);
         sq_acc = '0;
         raw_acc = 0;
         blk_count = '0;
         done = 1'b1;
      end else begin
         blk_count = CNT_W'(n);
      end
      if (phase == PH_ZERO) begin
         zero_ofs = 0;
         if (phase_ticks + 1 >= count_limit(first_ticks)) begin
            zero_ofs = clamp16(-longint'(raw_mean));
            phase = PH_RMS;
            phase_ticks = 0;
         end else begin
            phase_ticks = (phase_ticks + 1) & 'hfff;
         end
      end else if (phase == PH_RMS) begin
         rms_ofs = 0;
         if (phase_ticks + 1 >= count_limit(second_ticks)) begin
            rms_ofs = clamp16(-longint'(scaled_rms));
            phase = PH_IDLE;
            phase_ticks = 0;
         end else begin
            phase_ticks = (phase_ticks + 1) & 'hfff;
         end
      end
      if (phase == PH_RMS) rms_ofs = 0;
      if (done) begin
         r.phase = phase;
         expected_readings.push_back(r);
      end
   endtask

   task automatic set_meter_reg(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SAMPLES_PER_BLOCK: blk_len = data;
         CSR_MID_SCALE:         mid = data[ADC_BITS-1:0];
         CSR_GHOST_THRESHOLD:   ghost = data[GHOST_W-1:0];
         CSR_FIRST_CAL_TICKS:   first_ticks = data;
         CSR_SECOND_CAL_TICKS:  second_ticks = data;
         default: ;
      endcase
   endtask

   task automatic queue_tick(input int adc, input bit cal);
      tick_item_type t;
      t.adc = ADC_BITS'(adc);
      t.cal = cal;
      pending_ticks.push_back(t);
   endtask

   task automatic queue_random_ticks(input int count, input int amp, input int cal_odds);
      int s;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) s = $urandom_range(1023);
         else s = int'(mid) + int'($urandom_range(2 * amp)) - amp;
         if (s < 0) s = 0;
         if (s > 1023) s = 1023;
         queue_tick(s, $urandom_range(cal_odds - 1) == 0);
      end
   endtask

   // block is idle once nothing is queued, in flight or owed
   task automatic wait_meter_quiet();
      while (pending_ticks.size() != 0 || req_valid || expected_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sample driver
   always @(posedge clock) begin
      tick_item_type staged;
      if (!reset) begin
         if (req_valid && !req_stall) advance_meter(req_adc_sample, req_calibrate_request);
         if (!req_valid || !req_stall) begin
            if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
               staged = pending_ticks.pop_front();
               req_valid <= 1'b1;
               req_adc_sample <= staged.adc;
               req_calibrate_request <= staged.cal;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      reading_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("unexpected result: rms_voltage %0d calibration_phase %0d",
                      rsp_rms_voltage, rsp_calibration_phase);
               failures++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_rms_voltage !== want.rms) begin
                  $error("rms_voltage: expected %0d, got %0d", want.rms, rsp_rms_voltage);
                  failures++;
               end
               if (rsp_calibration_phase !== want.phase) begin
                  $error("calibration_phase: expected %0d, got %0d",
                         want.phase, rsp_calibration_phase);
                  failures++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 19);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // one-sample blocks, short calibration phases
      set_meter_reg(CSR_SAMPLES_PER_BLOCK, 12'd1);
      set_meter_reg(CSR_MID_SCALE, 12'd512);
      set_meter_reg(CSR_GHOST_THRESHOLD, 12'd0);
      set_meter_reg(CSR_FIRST_CAL_TICKS, 12'd3);
      set_meter_reg(CSR_SECOND_CAL_TICKS, 12'd2);
      queue_tick(0, 1'b0);
      queue_tick(1023, 1'b0);
      queue_tick(512, 1'b0);
      queue_tick(511, 1'b0);
      queue_tick(513, 1'b0);
      queue_tick(1023, 1'b1);
      queue_tick(1023, 1'b0);
      queue_tick(1023, 1'b0);
      queue_tick(0, 1'b0);
      queue_tick(700, 1'b1);   // request during RMS phase, tick count kept
      queue_tick(700, 1'b0);
      queue_tick(700, 1'b0);
      queue_tick(700, 1'b0);
      queue_tick(300, 1'b0);
      queue_tick(800, 1'b0);
      wait_meter_quiet();

      // scale extremes, threshold at max
      set_meter_reg(CSR_SAMPLES_PER_BLOCK, 12'd2);
      set_meter_reg(CSR_MID_SCALE, 12'd0);
      set_meter_reg(CSR_GHOST_THRESHOLD, 12'hfff);
      queue_tick(1023, 1'b0);
      queue_tick(1023, 1'b0);
      queue_tick(1023, 1'b0);
      queue_tick(0, 1'b0);
      queue_tick(0, 1'b0);
      queue_tick(0, 1'b0);
      wait_meter_quiet();
      set_meter_reg(CSR_MID_SCALE, 12'hfff);
      set_meter_reg(CSR_GHOST_THRESHOLD, 12'd3);
      queue_tick(0, 1'b0);
      queue_tick(0, 1'b0);
      queue_tick(1023, 1'b1);
      queue_tick(1023, 1'b0);
      wait_meter_quiet();

      for (int p = 0; p < 8; p++) begin
         set_meter_reg(CSR_SAMPLES_PER_BLOCK, CSR_DATA_W'(($urandom_range(7) == 0) ?
                       $urandom_range(64, 17) : $urandom_range(16, 1)));
         set_meter_reg(CSR_MID_SCALE, CSR_DATA_W'($urandom_range(4095)));
         set_meter_reg(CSR_GHOST_THRESHOLD, CSR_DATA_W'(($urandom_range(3) == 0) ?
                       $urandom_range(4095) : $urandom_range(120)));
         set_meter_reg(CSR_FIRST_CAL_TICKS, CSR_DATA_W'($urandom_range(24, 1)));
         set_meter_reg(CSR_SECOND_CAL_TICKS, CSR_DATA_W'($urandom_range(24, 1)));
         case (p % 3)
            0: queue_random_ticks(70, 3, 50);
            1: queue_random_ticks(70, 40, 50);
            default: queue_random_ticks(70, 511, 50);
         endcase
         wait_meter_quiet();
      end

      // longest block and calibration lengths, then the block cut short by a smaller length
      set_meter_reg(CSR_SAMPLES_PER_BLOCK, 12'd0);
      set_meter_reg(CSR_FIRST_CAL_TICKS, 12'd0);
      set_meter_reg(CSR_SECOND_CAL_TICKS, 12'd0);
      set_meter_reg(CSR_GHOST_THRESHOLD, CSR_DATA_W'($urandom_range(60)));
      queue_tick($urandom_range(1023), 1'b1);
      queue_random_ticks(299, 300, 100000);
      wait_meter_quiet();
      set_meter_reg(CSR_SAMPLES_PER_BLOCK, 12'd5);
      queue_random_ticks(4, 300, 100000);
      wait_meter_quiet();

      if (failures == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
